// File: hw/rtl/vtfs_pkg.sv
// ----------------------------------------------------------------------------
// vtfs_pkg
// shared types and constants of the tangent frame sanitizer
// ----------------------------------------------------------------------------
package vtfs_pkg;

  localparam int SRC_W = 32;

  // register indexes, taken from paddr[2]
  localparam logic REG_MIN_THR  = 1'b0;
  localparam logic REG_AXIS_THR = 1'b1;

  localparam logic [15:0] MIN_THR_RESET  = 16'd7;
  localparam logic [14:0] AXIS_THR_RESET = 15'd16368;

  // magnitudes are aligned so that the largest lies in [2^29, 2^30)
  localparam int ALIGN_BITS = 30;
  localparam int SQRT_STEPS = 32;

  typedef struct packed {
    logic [15:0] min_thr;
    logic [14:0] axis_thr;
  } cfg_t;

  typedef struct packed {
    logic signed [SRC_W-1:0] nx;
    logic signed [SRC_W-1:0] ny;
    logic signed [SRC_W-1:0] nz;
    logic signed [SRC_W-1:0] tx;
    logic signed [SRC_W-1:0] ty;
    logic signed [SRC_W-1:0] tz;
    logic signed [SRC_W-1:0] bx;
    logic signed [SRC_W-1:0] by;
    logic signed [SRC_W-1:0] bz;
  } src_t;

endpackage

// File: hw/rtl/vtfs_regs.sv
// ----------------------------------------------------------------------------
// vtfs_regs
// apb register file holding the two thresholds
// ----------------------------------------------------------------------------
module vtfs_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output vtfs_pkg::cfg_t     cfg
);

  logic wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_thr  <= vtfs_pkg::MIN_THR_RESET;
      cfg.axis_thr <= vtfs_pkg::AXIS_THR_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        vtfs_pkg::REG_MIN_THR:  cfg.min_thr  <= pwdata[15:0];
        vtfs_pkg::REG_AXIS_THR: cfg.axis_thr <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      vtfs_pkg::REG_MIN_THR:  prdata = {16'b0, cfg.min_thr};
      vtfs_pkg::REG_AXIS_THR: prdata = {17'b0, cfg.axis_thr};
      default:                prdata = 32'b0;
    endcase
  end

endmodule

// File: hw/rtl/vtfs_front.sv
// ----------------------------------------------------------------------------
// vtfs_front
// accepts source words and queues them ahead of the frame pipeline
// ----------------------------------------------------------------------------
module vtfs_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  vtfs_pkg::src_t     src_in,
  output logic               q_valid,
  output vtfs_pkg::src_t     q_word
);

  vtfs_pkg::src_t slots [2];
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       push;
  logic       pop;

  assign busy    = (count == 2'd2);
  assign push    = start && !busy;
  // the pipeline behind never stalls, so a queued word leaves next cycle
  assign pop     = (count != 2'd0);
  assign q_valid = pop;
  assign q_word  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= src_in;
  end

endmodule

// File: hw/rtl/vtfs_norm.sv
// ----------------------------------------------------------------------------
// vtfs_norm
// pipelined safe normalize: threshold test, alignment, square root, divide
// ----------------------------------------------------------------------------
module vtfs_norm #(
  parameter int W        = 32,
  parameter int F        = 16,
  parameter int IN_FRAC  = 16,
  parameter int OF       = 14,
  parameter int DW       = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [W-1:0]  vec [3],
  input  logic [15:0]          thr,
  input  logic [DW-1:0]        side_in,
  output logic                 out_valid,
  output logic                 ok,
  output logic signed [OF+1:0] unit [3],
  output logic [DW-1:0]        side_out
);

  localparam int UW  = OF + 2;
  localparam int QB  = OF + 1;
  localparam int AB  = vtfs_pkg::ALIGN_BITS;
  localparam int SQ  = vtfs_pkg::SQRT_STEPS;
  localparam int BLW = $clog2(W + 1);
  localparam int NW  = 32 + OF;
  localparam int CW  = (W > 16) ? W : 16;
  localparam int LAT = 39 + QB;

  logic [W-1:0] mag_c [3];
  logic [W-1:0] max_c;
  logic [CW-1:0] mx;
  logic [CW-1:0] tx;
  logic          fail_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = vec[i][W-1] ? (~vec[i] + 1'b1) : vec[i];
    end
    max_c = mag_c[0];
    if (mag_c[1] > max_c) max_c = mag_c[1];
    if (mag_c[2] > max_c) max_c = mag_c[2];
    mx = CW'(max_c);
    tx = CW'(thr);
  end

  // threshold is in input fraction bits; compare exactly at this scale
  generate
    if (F > IN_FRAC) begin : g_up
      localparam int S = F - IN_FRAC;
      logic [CW-1:0] ceil_c;
      assign ceil_c = (mx >> S) + CW'(|(mx & ({CW{1'b1}} >> (CW - S))));
      assign fail_c = (ceil_c <= tx) || (max_c == '0);
    end else if (F == IN_FRAC) begin : g_eq
      assign fail_c = (mx <= tx) || (max_c == '0);
    end else begin : g_dn
      assign fail_c = (mx <= (tx >> (IN_FRAC - F))) || (max_c == '0);
    end
  endgenerate

  // alignment stages
  logic [W-1:0]   mag0 [3];
  logic           sgn0 [3];
  logic [W-1:0]   max0;
  logic           fail0;
  logic [W-1:0]   mag1 [3];
  logic           sgn1 [3];
  logic           fail1;
  logic [BLW-1:0] bl1;
  logic [BLW-1:0] bl_c;
  logic [AB-1:0]  u2 [3];
  logic           sgn2 [3];
  logic           fail2;
  logic [AB-1:0]  u3 [3];
  logic [2*AB-1:0] sq3 [3];
  logic           sgn3 [3];
  logic           fail3;

  always_comb begin
    bl_c = '0;
    for (int i = 0; i < W; i++) begin
      if (max0[i]) bl_c = BLW'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      mag0[i] <= mag_c[i];
      sgn0[i] <= vec[i][W-1];
      mag1[i] <= mag0[i];
      sgn1[i] <= sgn0[i];
      u2[i]   <= AB'({mag1[i], {AB{1'b0}}} >> bl1);
      sgn2[i] <= sgn1[i];
      u3[i]   <= u2[i];
      sq3[i]  <= u2[i] * u2[i];
      sgn3[i] <= sgn2[i];
    end
    max0  <= max_c;
    fail0 <= fail_c;
    bl1   <= bl_c;
    fail1 <= fail0;
    fail2 <= fail1;
    fail3 <= fail2;
  end

  // square root, one result bit a stage
  logic [2*AB+1:0] sx [SQ+1];
  logic [2*AB+2:0] sr [SQ+1];
  logic [AB-1:0]   su [SQ+1][3];
  logic            ss [SQ+1][3];
  logic            sf [SQ+1];

  always_ff @(posedge clk) begin
    sx[0] <= (2*AB+2)'(sq3[0]) + (2*AB+2)'(sq3[1]) + (2*AB+2)'(sq3[2]);
    sr[0] <= '0;
    for (int i = 0; i < 3; i++) begin
      su[0][i] <= u3[i];
      ss[0][i] <= sgn3[i];
    end
    sf[0] <= fail3;
  end

  generate
    for (genvar k = 0; k < SQ; k++) begin : g_sqrt
      localparam logic [2*AB+2:0] BIT = (2*AB+3)'(1) << (2*AB + 2 - 2*k);
      logic [2*AB+2:0] trial;
      logic            take;
      assign trial = sr[k] + BIT;
      assign take  = ({1'b0, sx[k]} >= trial);
      always_ff @(posedge clk) begin
        if (take) begin
          sx[k+1] <= (2*AB+2)'({1'b0, sx[k]} - trial);
          sr[k+1] <= (sr[k] >> 1) + BIT;
        end else begin
          sx[k+1] <= sx[k];
          sr[k+1] <= sr[k] >> 1;
        end
        for (int i = 0; i < 3; i++) begin
          su[k+1][i] <= su[k][i];
          ss[k+1][i] <= ss[k][i];
        end
        sf[k+1] <= sf[k];
      end
    end
  endgenerate

  // restoring divide, one quotient bit a stage, three lanes
  logic [NW-1:0] dr [QB+1][3];
  logic [QB-1:0] dq [QB+1][3];
  logic [31:0]   dl [QB+1];
  logic          ds [QB+1][3];
  logic          df [QB+1];
  logic [31:0]   len_c;

  assign len_c = sr[SQ][31:0];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dr[0][i] <= (NW'(su[SQ][i]) << OF) + NW'(len_c >> 1);
      dq[0][i] <= '0;
      ds[0][i] <= ss[SQ][i];
    end
    dl[0] <= len_c;
    df[0] <= sf[SQ];
  end

  generate
    for (genvar j = 0; j < QB; j++) begin : g_div
      localparam int B = QB - 1 - j;
      logic [NW-1:0] dsh;
      assign dsh = NW'(dl[j]) << B;
      always_ff @(posedge clk) begin
        for (int i = 0; i < 3; i++) begin
          if (dr[j][i] >= dsh) begin
            dr[j+1][i] <= dr[j][i] - dsh;
            dq[j+1][i] <= dq[j][i] | (QB'(1) << B);
          end else begin
            dr[j+1][i] <= dr[j][i];
            dq[j+1][i] <= dq[j][i];
          end
          ds[j+1][i] <= ds[j][i];
        end
        dl[j+1] <= dl[j];
        df[j+1] <= df[j];
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (df[QB]) unit[i] <= '0;
      else if (ds[QB][i]) unit[i] <= -$signed(UW'(dq[QB][i]));
      else unit[i] <= $signed(UW'(dq[QB][i]));
    end
    ok <= !df[QB];
  end

  // side data and valid follow the datapath
  logic [DW-1:0]  sd [LAT];
  logic [LAT-1:0] vd;

  always_ff @(posedge clk) begin
    sd[0] <= side_in;
    for (int k = 1; k < LAT; k++) sd[k] <= sd[k-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= '0;
    end else begin
      vd <= {vd[LAT-2:0], in_valid};
    end
  end

  assign side_out  = sd[LAT-1];
  assign out_valid = vd[LAT-1];

endmodule

// File: hw/rtl/vtfs_back.sv
// ----------------------------------------------------------------------------
// vtfs_back
// frame pipeline: normalize, project, fall back, cross, handedness
// ----------------------------------------------------------------------------
module vtfs_back #(
  parameter int IN_FRAC = 16,
  parameter int OF      = 14
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  vtfs_pkg::src_t       q_word,
  input  vtfs_pkg::cfg_t       cfg,
  output logic                 done,
  output logic signed [OF+1:0] n_out [3],
  output logic signed [OF+1:0] t_out [3],
  output logic signed [OF+1:0] b_out [3]
);

  localparam int UW   = OF + 2;
  localparam int SW   = vtfs_pkg::SRC_W;
  localparam int PW   = 2 * UW;
  localparam int SUMW = PW + 2;
  localparam int DDW  = UW + 1;
  localparam int RW   = 2 * UW + 2;
  localparam int CRW  = 2 * UW + 1;
  localparam int CQW  = UW + 2;
  localparam int PQW  = CQW + UW;
  localparam int AXW  = OF + 16;
  localparam logic signed [UW-1:0] ONE = UW'(64'd1 << OF);
  localparam logic signed [UW-1:0] ZERO = '0;

  // ---------------- first normalize: three sources in parallel
  logic signed [SW-1:0] nsrc [3];
  logic signed [SW-1:0] tsrc [3];
  logic signed [SW-1:0] bsrc [3];
  logic signed [UW-1:0] na [3];
  logic signed [UW-1:0] ta [3];
  logic signed [UW-1:0] sa [3];
  logic                 na_ok, ta_ok, sa_ok, a_valid;

  assign nsrc[0] = q_word.nx;
  assign nsrc[1] = q_word.ny;
  assign nsrc[2] = q_word.nz;
  assign tsrc[0] = q_word.tx;
  assign tsrc[1] = q_word.ty;
  assign tsrc[2] = q_word.tz;
  assign bsrc[0] = q_word.bx;
  assign bsrc[1] = q_word.by;
  assign bsrc[2] = q_word.bz;

  vtfs_norm #(.W(SW), .F(IN_FRAC), .IN_FRAC(IN_FRAC), .OF(OF), .DW(1)) u_norm_n (
    .clk(clk), .rst(rst), .in_valid(q_valid), .vec(nsrc), .thr(cfg.min_thr),
    .side_in(1'b0), .out_valid(a_valid), .ok(na_ok), .unit(na), .side_out()
  );

  vtfs_norm #(.W(SW), .F(IN_FRAC), .IN_FRAC(IN_FRAC), .OF(OF), .DW(1)) u_norm_t (
    .clk(clk), .rst(rst), .in_valid(q_valid), .vec(tsrc), .thr(cfg.min_thr),
    .side_in(1'b0), .out_valid(), .ok(ta_ok), .unit(ta), .side_out()
  );

  vtfs_norm #(.W(SW), .F(IN_FRAC), .IN_FRAC(IN_FRAC), .OF(OF), .DW(1)) u_norm_b (
    .clk(clk), .rst(rst), .in_valid(q_valid), .vec(bsrc), .thr(cfg.min_thr),
    .side_in(1'b0), .out_valid(), .ok(sa_ok), .unit(sa), .side_out()
  );

  // ---------------- tangent minus its projection onto the normal
  logic signed [UW-1:0]   n1 [3], t1 [3], s1 [3];
  logic signed [PW-1:0]   p1 [3];
  logic                   tok1, sok1;
  logic signed [UW-1:0]   n2 [3], t2 [3], s2 [3];
  logic signed [DDW-1:0]  d2;
  logic                   tok2, sok2;
  logic signed [UW-1:0]   n3 [3], t3 [3], s3 [3];
  logic signed [CRW-1:0]  nd3 [3];
  logic                   tok3, sok3;
  logic signed [UW-1:0]   n4 [3], s4 [3];
  logic signed [RW-1:0]   r4 [3];
  logic                   tok4, sok4;
  logic [3:0]             pv;
  logic signed [SUMW-1:0] dot_c;
  logic [SUMW-1:0]        dmag_c;
  logic [SUMW-1:0]        drnd_c;

  always_comb begin
    dot_c  = SUMW'(p1[0]) + SUMW'(p1[1]) + SUMW'(p1[2]);
    dmag_c = dot_c[SUMW-1] ? (~dot_c + 1'b1) : dot_c;
    // half away from zero
    drnd_c = (dmag_c + (SUMW'(1) << (OF - 1))) >> OF;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      n1[i]  <= na_ok ? na[i] : ((i == 1) ? ONE : ZERO);
      t1[i]  <= ta[i];
      s1[i]  <= sa[i];
      p1[i]  <= ta[i] * (na_ok ? na[i] : ((i == 1) ? ONE : ZERO));
      n2[i]  <= n1[i];
      t2[i]  <= t1[i];
      s2[i]  <= s1[i];
      n3[i]  <= n2[i];
      t3[i]  <= t2[i];
      s3[i]  <= s2[i];
      nd3[i] <= n2[i] * d2;
      n4[i]  <= n3[i];
      s4[i]  <= s3[i];
      r4[i]  <= (RW'(t3[i]) <<< OF) - RW'(nd3[i]);
    end
    tok1 <= ta_ok;
    sok1 <= sa_ok;
    d2   <= dot_c[SUMW-1] ? -$signed(DDW'(drnd_c)) : $signed(DDW'(drnd_c));
    tok2 <= tok1;
    sok2 <= sok1;
    tok3 <= tok2;
    sok3 <= sok2;
    tok4 <= tok3;
    sok4 <= sok3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
    end else begin
      pv <= {pv[2:0], a_valid};
    end
  end

  // ---------------- residual normalize, then normalize once more
  localparam int SW1 = 6 * UW + 2;
  logic [SW1-1:0]       side_r_in, side_r_out;
  logic signed [UW-1:0] tr [3];
  logic                 tr_ok, r_valid;

  assign side_r_in = {n4[0], n4[1], n4[2], s4[0], s4[1], s4[2], sok4, tok4};

  vtfs_norm #(.W(RW), .F(2*OF), .IN_FRAC(IN_FRAC), .OF(OF), .DW(SW1)) u_norm_r (
    .clk(clk), .rst(rst), .in_valid(pv[3]), .vec(r4), .thr(cfg.min_thr),
    .side_in(side_r_in), .out_valid(r_valid), .ok(tr_ok), .unit(tr),
    .side_out(side_r_out)
  );

  logic [SW1-1:0]       side_2_in, side_2_out;
  logic signed [UW-1:0] tt [3];
  logic                 tt_ok, v2_valid;

  assign side_2_in = {side_r_out[SW1-1:1], side_r_out[0] && tr_ok};

  vtfs_norm #(.W(UW), .F(OF), .IN_FRAC(IN_FRAC), .OF(OF), .DW(SW1)) u_norm_2 (
    .clk(clk), .rst(rst), .in_valid(r_valid), .vec(tr), .thr(cfg.min_thr),
    .side_in(side_2_in), .out_valid(v2_valid), .ok(tt_ok), .unit(tt),
    .side_out(side_2_out)
  );

  // ---------------- fallback tangent from a helper axis
  logic signed [UW-1:0] n5 [3], s5 [3], t5 [3], f5 [3];
  logic                 tok5, sok5, v5;
  logic signed [UW-1:0] n5_c [3];
  logic [UW-1:0]        ny_mag;
  logic                 use_y;

  always_comb begin
    n5_c[0] = $signed(side_2_out[SW1-1 -: UW]);
    n5_c[1] = $signed(side_2_out[SW1-1-UW -: UW]);
    n5_c[2] = $signed(side_2_out[SW1-1-2*UW -: UW]);
    ny_mag  = n5_c[1][UW-1] ? (~n5_c[1] + 1'b1) : n5_c[1];
    use_y   = ((AXW'(ny_mag) << 14) < (AXW'(cfg.axis_thr) << OF));
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      n5[i] <= n5_c[i];
      t5[i] <= tt[i];
    end
    s5[0] <= $signed(side_2_out[SW1-1-3*UW -: UW]);
    s5[1] <= $signed(side_2_out[SW1-1-4*UW -: UW]);
    s5[2] <= $signed(side_2_out[SW1-1-5*UW -: UW]);
    sok5  <= side_2_out[1];
    tok5  <= side_2_out[0] && tt_ok;
    if (use_y) begin
      f5[0] <= n5_c[2];
      f5[1] <= ZERO;
      f5[2] <= -n5_c[0];
    end else begin
      f5[0] <= ZERO;
      f5[1] <= -n5_c[2];
      f5[2] <= n5_c[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v2_valid;
    end
  end

  localparam int SW2 = 9 * UW + 2;
  logic [SW2-1:0]       side_f_in, side_f_out;
  logic signed [UW-1:0] tf [3];
  logic                 tf_ok, f_valid;

  assign side_f_in = {n5[0], n5[1], n5[2], s5[0], s5[1], s5[2],
                      t5[0], t5[1], t5[2], sok5, tok5};

  vtfs_norm #(.W(UW), .F(OF), .IN_FRAC(IN_FRAC), .OF(OF), .DW(SW2)) u_norm_f (
    .clk(clk), .rst(rst), .in_valid(v5), .vec(f5), .thr(cfg.min_thr),
    .side_in(side_f_in), .out_valid(f_valid), .ok(tf_ok), .unit(tf),
    .side_out(side_f_out)
  );

  // ---------------- tangent select, cross product, handedness
  logic signed [UW-1:0]  n6 [3], s6 [3], t6 [3];
  logic                  sok6;
  logic signed [UW-1:0]  tg_c [3];
  logic                  tok_c;
  logic signed [UW-1:0]  n7 [3], t7 [3], s7 [3];
  logic signed [PW-1:0]  cp7 [6];
  logic                  sok7;
  logic signed [UW-1:0]  n8 [3], t8 [3], s8 [3];
  logic signed [CRW-1:0] c8 [3];
  logic signed [CQW-1:0] cq8 [3];
  logic                  sok8;
  logic signed [UW-1:0]  n9 [3], t9 [3];
  logic signed [CRW-1:0] c9 [3];
  logic signed [PQW-1:0] pq9 [3];
  logic                  sok9;
  logic signed [UW-1:0]  n10 [3], t10 [3];
  logic signed [CRW-1:0] c10 [3];
  logic                  neg10;
  logic [4:0]            xv;
  logic signed [CRW-1:0] c_c [3];
  logic [CRW-1:0]        cmag_c [3];
  logic [CRW-1:0]        crnd_c [3];
  logic signed [PQW+1:0] hd_c;

  always_comb begin
    tok_c = side_f_out[0];
    for (int i = 0; i < 3; i++) begin
      if (tok_c) tg_c[i] = $signed(side_f_out[SW2-1-(6+i)*UW -: UW]);
      else if (tf_ok) tg_c[i] = tf[i];
      else tg_c[i] = (i == 0) ? ONE : ZERO;
    end
    c_c[0] = CRW'(cp7[0]) - CRW'(cp7[1]);
    c_c[1] = CRW'(cp7[2]) - CRW'(cp7[3]);
    c_c[2] = CRW'(cp7[4]) - CRW'(cp7[5]);
    for (int i = 0; i < 3; i++) begin
      cmag_c[i] = c_c[i][CRW-1] ? (~c_c[i] + 1'b1) : c_c[i];
      crnd_c[i] = (cmag_c[i] + (CRW'(1) << (OF - 1))) >> OF;
    end
    hd_c = (PQW+2)'(pq9[0]) + (PQW+2)'(pq9[1]) + (PQW+2)'(pq9[2]);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      n6[i]  <= $signed(side_f_out[SW2-1-i*UW -: UW]);
      s6[i]  <= $signed(side_f_out[SW2-1-(3+i)*UW -: UW]);
      t6[i]  <= tg_c[i];
      n7[i]  <= n6[i];
      t7[i]  <= t6[i];
      s7[i]  <= s6[i];
      n8[i]  <= n7[i];
      t8[i]  <= t7[i];
      s8[i]  <= s7[i];
      c8[i]  <= c_c[i];
      cq8[i] <= c_c[i][CRW-1] ? -$signed(CQW'(crnd_c[i])) : $signed(CQW'(crnd_c[i]));
      n9[i]  <= n8[i];
      t9[i]  <= t8[i];
      c9[i]  <= c8[i];
      pq9[i] <= cq8[i] * s8[i];
      n10[i] <= n9[i];
      t10[i] <= t9[i];
      c10[i] <= c9[i];
    end
    cp7[0] <= n6[1] * t6[2];
    cp7[1] <= n6[2] * t6[1];
    cp7[2] <= n6[2] * t6[0];
    cp7[3] <= n6[0] * t6[2];
    cp7[4] <= n6[0] * t6[1];
    cp7[5] <= n6[1] * t6[0];
    sok6  <= side_f_out[1];
    sok7  <= sok6;
    sok8  <= sok7;
    sok9  <= sok8;
    neg10 <= sok9 && hd_c[PQW+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      xv <= '0;
    end else begin
      xv <= {xv[3:0], f_valid};
    end
  end

  // ---------------- bitangent normalize and output word
  localparam int SW3 = 6 * UW + 1;
  logic [SW3-1:0]       side_x_in, side_x_out;
  logic signed [UW-1:0] bx [3];
  logic                 bx_ok, x_valid;

  assign side_x_in = {n10[0], n10[1], n10[2], t10[0], t10[1], t10[2], neg10};

  vtfs_norm #(.W(CRW), .F(2*OF), .IN_FRAC(IN_FRAC), .OF(OF), .DW(SW3)) u_norm_x (
    .clk(clk), .rst(rst), .in_valid(xv[4]), .vec(c10), .thr(cfg.min_thr),
    .side_in(side_x_in), .out_valid(x_valid), .ok(bx_ok), .unit(bx),
    .side_out(side_x_out)
  );

  logic signed [UW-1:0] bsel_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      bsel_c[i] = bx_ok ? bx[i] : ((i == 2) ? ONE : ZERO);
      if (side_x_out[0]) bsel_c[i] = -bsel_c[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      n_out[i] <= $signed(side_x_out[SW3-1-i*UW -: UW]);
      t_out[i] <= $signed(side_x_out[SW3-1-(3+i)*UW -: UW]);
      b_out[i] <= bsel_c[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= x_valid;
    end
  end

endmodule

// File: hw/rtl/vertex_tangent_frame_sanitizer.sv
// ----------------------------------------------------------------------------
// vertex_tangent_frame_sanitizer
// orthonormal tangent frame from a vertex normal, tangent and bitangent
// ----------------------------------------------------------------------------
//  channel   signals                         moves
//  source    start / busy, normal_*..        one word of nine Q16.16 values
//  result    done, unit_normal_*..           one word of nine unit values
//  config    psel penable pwrite paddr ...   apb register access
//
//  a new word is taken every cycle while busy is low; each word passes
//  through the five chained normalize units, each with a 32-step square
//  root and an OUT_FRAC_BITS+1 step divider
//  rst is synchronous and clears all valid state; thresholds go to reset value
//  results come out with a one-cycle done strobe and cannot be held off
// ----------------------------------------------------------------------------
module vertex_tangent_frame_sanitizer #(
  parameter int IN_FRAC_BITS  = 16,
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [31:0]              normal_x,
  input  logic signed [31:0]              normal_y,
  input  logic signed [31:0]              normal_z,
  input  logic signed [31:0]              tangent_x,
  input  logic signed [31:0]              tangent_y,
  input  logic signed [31:0]              tangent_z,
  input  logic signed [31:0]              bitangent_x,
  input  logic signed [31:0]              bitangent_y,
  input  logic signed [31:0]              bitangent_z,
  output logic                            done,
  output logic signed [OUT_FRAC_BITS+1:0] unit_normal_x,
  output logic signed [OUT_FRAC_BITS+1:0] unit_normal_y,
  output logic signed [OUT_FRAC_BITS+1:0] unit_normal_z,
  output logic signed [OUT_FRAC_BITS+1:0] unit_tangent_x,
  output logic signed [OUT_FRAC_BITS+1:0] unit_tangent_y,
  output logic signed [OUT_FRAC_BITS+1:0] unit_tangent_z,
  output logic signed [OUT_FRAC_BITS+1:0] unit_bitangent_x,
  output logic signed [OUT_FRAC_BITS+1:0] unit_bitangent_y,
  output logic signed [OUT_FRAC_BITS+1:0] unit_bitangent_z,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  vtfs_pkg::cfg_t cfg;
  vtfs_pkg::src_t src_in;
  vtfs_pkg::src_t q_word;
  logic           q_valid;
  logic signed [OUT_FRAC_BITS+1:0] n_out [3];
  logic signed [OUT_FRAC_BITS+1:0] t_out [3];
  logic signed [OUT_FRAC_BITS+1:0] b_out [3];

  assign src_in = '{nx: normal_x, ny: normal_y, nz: normal_z,
                    tx: tangent_x, ty: tangent_y, tz: tangent_z,
                    bx: bitangent_x, by: bitangent_y, bz: bitangent_z};

  vtfs_regs u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  vtfs_front u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .src_in(src_in),
    .q_valid(q_valid), .q_word(q_word)
  );

  vtfs_back #(.IN_FRAC(IN_FRAC_BITS), .OF(OUT_FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_word(q_word), .cfg(cfg),
    .done(done), .n_out(n_out), .t_out(t_out), .b_out(b_out)
  );

  assign unit_normal_x    = n_out[0];
  assign unit_normal_y    = n_out[1];
  assign unit_normal_z    = n_out[2];
  assign unit_tangent_x   = t_out[0];
  assign unit_tangent_y   = t_out[1];
  assign unit_tangent_z   = t_out[2];
  assign unit_bitangent_x = b_out[0];
  assign unit_bitangent_y = b_out[1];
  assign unit_bitangent_z = b_out[2];

endmodule

// File: hw/rtl/vtfs_checker.sv
// ----------------------------------------------------------------------------
// vtfs_checker
// port-level checks on the tangent frame sanitizer
// ----------------------------------------------------------------------------
module vtfs_checker (
  input logic               clk,
  input logic               rst,
  input logic               busy,
  input logic               done,
  input logic               pready,
  input logic signed [15:0] unit_normal_x,
  input logic signed [15:0] unit_normal_y,
  input logic signed [15:0] unit_normal_z,
  input logic signed [15:0] unit_tangent_x,
  input logic signed [15:0] unit_tangent_y,
  input logic signed [15:0] unit_tangent_z
);

  localparam logic signed [15:0] UNIT_MAX = 16'sd16384;
  localparam logic signed [15:0] UNIT_MIN = -16'sd16384;

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready dropped");

  // the pipeline drains every cycle, so the queue never fills
  a_no_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("source queue filled");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result word right after reset");

  a_normal_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (unit_normal_x <= UNIT_MAX) && (unit_normal_x >= UNIT_MIN) &&
             (unit_normal_y <= UNIT_MAX) && (unit_normal_y >= UNIT_MIN) &&
             (unit_normal_z <= UNIT_MAX) && (unit_normal_z >= UNIT_MIN))
    else $error("normal component out of unit range");

  a_tangent_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (unit_tangent_x <= UNIT_MAX) && (unit_tangent_x >= UNIT_MIN) &&
             (unit_tangent_y <= UNIT_MAX) && (unit_tangent_y >= UNIT_MIN) &&
             (unit_tangent_z <= UNIT_MAX) && (unit_tangent_z >= UNIT_MIN))
    else $error("tangent component out of unit range");

endmodule

bind vertex_tangent_frame_sanitizer vtfs_checker u_vtfs_checker (.*);
